// ----- rtl/framed_reply_checker_and_collector_core_defines.svh -----
// assertion helpers shared by the queue, front end and back end rtl files
`ifndef FRAMED_REPLY_CHECKER_AND_COLLECTOR_CORE_DEFINES_SVH
`define FRAMED_REPLY_CHECKER_AND_COLLECTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FRCC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FRCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/frcc_pkg.sv -----
`default_nettype none

package frcc_pkg;

   // default sizes handed to the top level parameters
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int NUM_SLAVES_DEF  = 3;
   localparam int MAX_WORDS_DEF   = 11;

   // register reset values
   localparam logic [7:0] START_MARKER_RESET = 8'h02;
   localparam logic [7:0] END_MARKER_RESET   = 8'h03;
   localparam logic [3:0] WORD_COUNT_RESET   = 4'd10;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_COUNT   = 2'd2;

   // input action codes
   localparam logic ACT_FRAME_BYTE = 1'b0;
   localparam logic ACT_TABLE_READ = 1'b1;

   // bytes ahead of the data words: marker, slave (2), function, start (2)
   localparam int HEADER_BYTES = 6;

   // width of a word count or word counter
   localparam int WORDS_W = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // command kinds
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic               done;
      logic               ok;
      logic [15:0]        slave;
      logic               commit;
      logic [15:0]        start;
      logic [WORDS_W-1:0] words;
      logic [1:0]         rd_slave;
      logic [3:0]         rd_index;
   } cmd_type;

   // commit handshake from back to front
   typedef struct packed {
      logic               done;
      logic [WORDS_W-1:0] idx;
   } commit_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/frcc_if.sv -----
`default_nettype none

// request channel: frame bytes and table reads
interface frcc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   logic       frame_start;
   logic [1:0] read_slave;
   logic [3:0] read_index;

   modport source (output valid, action, rx_byte, frame_start, read_slave, read_index,
                   input ready);
   modport sink   (input valid, action, rx_byte, frame_start, read_slave, read_index,
                   output ready);
endinterface

// response channel: one word per request
interface frcc_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_done;
   logic               frame_ok;
   logic [15:0]        frame_slave;
   logic signed [15:0] read_word;

   modport source (output valid, frame_done, frame_ok, frame_slave, read_word,
                   input ready);
   modport sink   (input valid, frame_done, frame_ok, frame_slave, read_word,
                   output ready);
endinterface

// register write channel
interface frcc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [frcc_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/frcc_ram.sv -----
`default_nettype none

module frcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/frcc_queue.sv -----
`default_nettype none

`include "framed_reply_checker_and_collector_core_defines.svh"

module frcc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire frcc_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output frcc_pkg::cmd_type      pop_data,
   output logic                   empty
);
   localparam int PTR_W = (frcc_pkg::QUEUE_DEPTH > 1) ? $clog2(frcc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(frcc_pkg::QUEUE_DEPTH + 1);

   frcc_pkg::cmd_type   entry_ff [frcc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == CNT_W'(frcc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(frcc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(frcc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `FRCC_ASSERT_IMPL(a_no_overflow, push && !pop, !full, "queue push while full")
   `FRCC_ASSERT_IMPL(a_no_underflow, pop, !empty, "queue pop while empty")

endmodule

`default_nettype wire

// ----- rtl/frcc_front.sv -----
`default_nettype none

`include "framed_reply_checker_and_collector_core_defines.svh"

module frcc_front #(
   parameter int NUM_SLAVES = frcc_pkg::NUM_SLAVES_DEF,
   parameter int MAX_WORDS  = frcc_pkg::MAX_WORDS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   frcc_req_if.sink                    req,
   frcc_csr_if.sink                    csr,
   input  wire logic                   q_full,
   output logic                        push,
   output frcc_pkg::cmd_type           cmd,
   input  wire frcc_pkg::commit_ctl_type commit_ctl,
   output logic [15:0]                 stage_data
);
   localparam int SW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   // fixed header positions
   localparam logic [5:0] POS_START    = 6'd0;
   localparam logic [5:0] POS_SLAVE_HI = 6'd1;
   localparam logic [5:0] POS_SLAVE_LO = 6'd2;
   localparam logic [5:0] POS_ADDR_HI  = 6'd4;
   localparam logic [5:0] POS_ADDR_LO  = 6'd5;
   localparam logic [5:0] POS_DATA     = 6'(frcc_pkg::HEADER_BYTES);
   localparam logic [4:0] POS_LIMIT    = 5'(frcc_pkg::HEADER_BYTES + 2 * MAX_WORDS + 2);

   // configuration
   logic [7:0]                     start_marker_ff;
   logic [7:0]                     end_marker_ff;
   logic [frcc_pkg::WORDS_W-1:0]   word_count_ff;

   // frame parse state
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] slave_ff, slave_in;
   logic [15:0] start_ff, start_in;
   logic        smatch_ff, smatch_in;
   logic        ematch_ff, ematch_in;
   logic [7:0]  hold_ff, hold_in;
   logic        commit_out_ff, commit_out_in;
   logic [15:0] staged_ff [MAX_WORDS];

   logic [frcc_pkg::WORDS_W-1:0] words;
   logic [5:0]  etx;
   logic [5:0]  p;
   logic [5:0]  off;
   logic [4:0]  k;
   logic [15:0] rx_sum;
   logic        ok;
   logic        slave_good;
   logic        stage_we;

   assign csr.ready = 1'b1;
   assign req.ready = !q_full && !commit_out_ff;
   assign push      = req.valid && req.ready;

   // staged word lookup for the commit sweep
   assign stage_data = (32'(commit_ctl.idx) < MAX_WORDS) ? staged_ff[commit_ctl.idx[SW-1:0]]
                                                          : 16'h0000;

   // classify the word and work out the next parse state
   always_comb begin
      words      = (32'(word_count_ff) > MAX_WORDS) ? frcc_pkg::WORDS_W'(MAX_WORDS)
                                                    : word_count_ff;
      etx        = POS_DATA + {1'b0, words, 1'b0};
      p          = req.frame_start ? POS_START : {1'b0, pos_ff};
      off        = p - POS_DATA;
      k          = off[5:1];
      rx_sum     = {hold_ff, req.rx_byte};
      ok         = smatch_ff && ematch_ff && (rx_sum == sum_ff);
      slave_good = (slave_ff != 16'h0000) && (32'(slave_ff) <= NUM_SLAVES);

      pos_in        = pos_ff;
      sum_in        = sum_ff;
      slave_in      = slave_ff;
      start_in      = start_ff;
      smatch_in     = smatch_ff;
      ematch_in     = ematch_ff;
      hold_in       = hold_ff;
      stage_we      = 1'b0;
      commit_out_in = commit_out_ff;
      cmd           = '0;

      if (commit_ctl.done) begin
         commit_out_in = 1'b0;
      end

      if (req.action == frcc_pkg::ACT_TABLE_READ) begin
         cmd.kind     = frcc_pkg::CMD_READ;
         cmd.rd_slave = req.read_slave;
         cmd.rd_index = req.read_index;
      end else begin
         cmd.kind = frcc_pkg::CMD_FRAME;
         if (p == POS_START) begin
            smatch_in = (req.rx_byte == start_marker_ff);
            sum_in    = {8'h00, req.rx_byte};
            pos_in    = 5'd1;
         end else if (p <= etx) begin
            sum_in = sum_ff + {8'h00, req.rx_byte};
            if (p == POS_SLAVE_HI || p == POS_SLAVE_LO) begin
               slave_in = {slave_ff[7:0], req.rx_byte};
            end else if (p == POS_ADDR_HI || p == POS_ADDR_LO) begin
               start_in = {start_ff[7:0], req.rx_byte};
            end else if (p == etx) begin
               ematch_in = (req.rx_byte == end_marker_ff);
            end else if (p >= POS_DATA) begin
               if (!off[0]) begin
                  hold_in = req.rx_byte;
               end else if (32'(k) < MAX_WORDS) begin
                  stage_we = 1'b1;
               end
            end
            pos_in = p[4:0] + 5'd1;
         end else if (p == etx + 6'd1) begin
            hold_in = req.rx_byte;
            pos_in  = p[4:0] + 5'd1;
         end else if (p == etx + 6'd2) begin
            // final checksum byte
            cmd.done   = 1'b1;
            cmd.ok     = ok;
            cmd.slave  = slave_ff;
            cmd.commit = ok && slave_good;
            cmd.start  = start_ff;
            cmd.words  = words;
            pos_in     = 5'd0;
            if (push && ok && slave_good) begin
               commit_out_in = 1'b1;
            end
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= frcc_pkg::START_MARKER_RESET;
         end_marker_ff   <= frcc_pkg::END_MARKER_RESET;
         word_count_ff   <= frcc_pkg::WORD_COUNT_RESET;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            frcc_pkg::CSR_START_MARKER: start_marker_ff <= csr.data;
            frcc_pkg::CSR_END_MARKER:   end_marker_ff   <= csr.data;
            frcc_pkg::CSR_WORD_COUNT:   word_count_ff   <= csr.data[frcc_pkg::WORDS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // parse state, updated on accepted words
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         sum_ff        <= '0;
         slave_ff      <= '0;
         start_ff      <= '0;
         smatch_ff     <= 1'b0;
         ematch_ff     <= 1'b0;
         hold_ff       <= '0;
         commit_out_ff <= 1'b0;
      end else begin
         commit_out_ff <= commit_out_in;
         if (push) begin
            pos_ff    <= pos_in;
            sum_ff    <= sum_in;
            slave_ff  <= slave_in;
            start_ff  <= start_in;
            smatch_ff <= smatch_in;
            ematch_ff <= ematch_in;
            hold_ff   <= hold_in;
         end
      end
   end

   // staged data words
   always_ff @(posedge clock) begin
      if (push && stage_we) begin
         staged_ff[k[SW-1:0]] <= {hold_ff, req.rx_byte};
      end
   end

   `FRCC_ASSERT_NEXT(a_commit_stall, push && cmd.commit, !req.ready,
                     "front accepted a word right after queuing a commit")
   `FRCC_ASSERT_IMPL(a_pos_range, 1'b1, pos_ff <= POS_LIMIT, "byte position past frame limit")

endmodule

`default_nettype wire

// ----- rtl/frcc_back.sv -----
`default_nettype none

`include "framed_reply_checker_and_collector_core_defines.svh"

module frcc_back #(
   parameter int TABLE_DEPTH = frcc_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_SLAVES  = frcc_pkg::NUM_SLAVES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire frcc_pkg::cmd_type q_data,
   output logic                   pop,
   output frcc_pkg::commit_ctl_type commit_ctl,
   input  wire logic [15:0]       stage_data,
   frcc_rsp_if.source             rsp
);
   localparam int DEPTH  = NUM_SLAVES * TABLE_DEPTH;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0]  state_ff, state_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               done_ff, done_in;
   logic               ok_ff, ok_in;
   logic [15:0]        slave_ff, slave_in;
   logic signed [15:0] word_ff, word_in;

   // read and commit context
   logic                          rd_ok_ff, rd_ok_in;
   logic                          vbit_ff, vbit_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [15:0]                   start_ff, start_in;
   logic [frcc_pkg::WORDS_W-1:0]  words_ff, words_in;
   logic [frcc_pkg::WORDS_W-1:0]  k_ff, k_in;

   // table entry valid bits, clear reads as zero
   logic [DEPTH-1:0] valid_ff;

   logic          rd_ok;
   logic [AW-1:0] rd_addr;
   logic          ram_re;
   logic          ram_we;
   logic [AW-1:0] wr_addr;
   logic [16:0]   addr17;
   logic [15:0]   ram_q;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.frame_done  = done_ff;
   assign rsp.frame_ok    = ok_ff;
   assign rsp.frame_slave = slave_ff;
   assign rsp.read_word   = word_ff;

   // read address check, commit address
   always_comb begin
      rd_ok   = (q_data.rd_slave != 2'd0) && (32'(q_data.rd_slave) <= NUM_SLAVES)
                && (32'(q_data.rd_index) < TABLE_DEPTH);
      rd_addr = AW'((32'(q_data.rd_slave) - 32'd1) * 32'(TABLE_DEPTH)
                    + 32'(q_data.rd_index));
      addr17  = {1'b0, start_ff} + 17'(k_ff);
      wr_addr = base_ff + AW'(addr17[IW-1:0]);
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      done_in         = done_ff;
      ok_in           = ok_ff;
      slave_in        = slave_ff;
      word_in         = word_ff;
      rd_ok_in        = rd_ok_ff;
      vbit_in         = vbit_ff;
      base_in         = base_ff;
      start_in        = start_ff;
      words_in        = words_ff;
      k_in            = k_ff;
      pop             = 1'b0;
      ram_re          = 1'b0;
      ram_we          = 1'b0;
      commit_ctl.idx  = k_ff;
      commit_ctl.done = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_empty && (!rsp_valid_ff || rsp.ready)) begin
               pop = 1'b1;
               if (q_data.kind == frcc_pkg::CMD_READ) begin
                  ram_re   = rd_ok;
                  rd_ok_in = rd_ok;
                  vbit_in  = rd_ok ? valid_ff[rd_addr] : 1'b0;
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  done_in      = q_data.done;
                  ok_in        = q_data.ok;
                  slave_in     = q_data.slave;
                  word_in      = '0;
                  if (q_data.commit) begin
                     base_in  = AW'((32'(q_data.slave[3:0]) - 32'd1) * 32'(TABLE_DEPTH));
                     start_in = q_data.start;
                     words_in = q_data.words;
                     k_in     = '0;
                     state_in = S_COMMIT;
                  end
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            done_in      = 1'b0;
            ok_in        = 1'b0;
            slave_in     = '0;
            word_in      = (rd_ok_ff && vbit_ff) ? ram_q : 16'sh0000;
            state_in     = S_IDLE;
         end
         S_COMMIT: begin
            if (k_ff < words_ff) begin
               ram_we = (addr17 < 17'(TABLE_DEPTH));
               k_in   = k_ff + 1'b1;
            end else begin
               commit_ctl.done = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // payload and context registers
   always_ff @(posedge clock) begin
      done_ff  <= done_in;
      ok_ff    <= ok_in;
      slave_ff <= slave_in;
      word_ff  <= word_in;
      rd_ok_ff <= rd_ok_in;
      vbit_ff  <= vbit_in;
      base_ff  <= base_in;
      start_ff <= start_in;
      words_ff <= words_in;
      k_ff     <= k_in;
   end

   // slave tables
   frcc_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (stage_data),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   `FRCC_ASSERT_IMPL(a_we_commit, ram_we, state_ff == S_COMMIT, "table write outside commit")
   `FRCC_ASSERT_NEXT(a_read_rsp, state_ff == S_READ, rsp_valid_ff,
                     "read finished without a response")

endmodule

`default_nettype wire

// ----- rtl/framed_reply_checker_and_collector_core.sv -----
// Reply frame checker and collector. Frame bytes (action 0) and table reads
// (action 1) enter on req_ch, one response per request leaves on rsp_ch in
// order. A frame is start marker, slave address, function, start address,
// min(word_count, MAX_WORDS) data words, end marker and a 16-bit big-endian
// sum of all bytes through the end marker; the final sum byte reports
// frame_done, frame_ok and the slave address, and a good frame for slave
// 1..NUM_SLAVES is copied into that slave's table from the start address,
// dropping words past TABLE_DEPTH. The front end takes one request per cycle
// into a two-entry queue while the queue is not full and no commit is
// pending; the back end retires a frame byte from its idle state and a table
// read through a read state (registered RAM read). After a good final byte
// the front end stops accepting until the commit sweep is through: the
// command reaches the back end through the queue, then one table write per
// data word goes through the single RAM write port, then a finish step
// signals done; queued requests or a stalled response delay the sweep.
// Tables read as zero after reset through per-entry valid bits; no clearing
// pass is needed. Registers on csr_ch: 0 start marker, 1 end marker,
// 2 word count; write them only while the block is idle.
`default_nettype none

module framed_reply_checker_and_collector_core #(
   parameter int TABLE_DEPTH = frcc_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_SLAVES  = frcc_pkg::NUM_SLAVES_DEF,
   parameter int MAX_WORDS   = frcc_pkg::MAX_WORDS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   frcc_req_if.sink   req_ch,
   frcc_rsp_if.source rsp_ch,
   frcc_csr_if.sink   csr_ch
);
   frcc_pkg::cmd_type        push_cmd;
   frcc_pkg::cmd_type        pop_cmd;
   frcc_pkg::commit_ctl_type commit_ctl;
   logic                     push;
   logic                     pop;
   logic                     q_full;
   logic                     q_empty;
   logic [15:0]              stage_data;

   // parse and classify
   frcc_front #(
      .NUM_SLAVES (NUM_SLAVES),
      .MAX_WORDS  (MAX_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd),
      .commit_ctl (commit_ctl),
      .stage_data (stage_data)
   );

   // command queue
   frcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   // tables, reads, commits and responses
   frcc_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUM_SLAVES  (NUM_SLAVES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (pop_cmd),
      .pop        (pop),
      .commit_ctl (commit_ctl),
      .stage_data (stage_data),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH         = frcc_pkg::TABLE_DEPTH_DEF;
   localparam int SLAVES        = frcc_pkg::NUM_SLAVES_DEF;
   localparam int WORDS_MAX     = frcc_pkg::MAX_WORDS_DEF;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int CYCLE_LIMIT   = 600000;

   // ways a frame can be spoiled
   typedef enum int {DMG_NONE, DMG_START, DMG_END, DMG_SUM} damage_type;

   typedef struct {
      logic       action;
      logic [7:0] rx_byte;
      logic       frame_start;
      logic [1:0] read_slave;
      logic [3:0] read_index;
   } req_word_type;

   typedef struct {
      logic               done;
      logic               ok;
      logic [15:0]        slave;
      logic signed [15:0] word;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   frcc_req_if req_ch();
   frcc_rsp_if rsp_ch();
   frcc_csr_if csr_ch();

   framed_reply_checker_and_collector_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // mirrored registers and frame tracking state
   logic [7:0]  cfg_start_mark;
   logic [7:0]  cfg_end_mark;
   logic [3:0]  cfg_words;
   logic [4:0]  pos;
   logic [15:0] sum;
   logic [15:0] hdr_slave;
   logic [15:0] hdr_start;
   logic        start_hit;
   logic        end_hit;
   logic [7:0]  hi_hold;
   logic [15:0] staged [WORDS_MAX];
   logic [15:0] tables [SLAVES][DEPTH];

   rsp_word_type owed_replies [$];
   logic [7:0]   frame_bytes [$];

   int errors       = 0;
   int items_sent   = 0;
   int cycles       = 0;
   bit gaps_on      = 1'b1;
   int hold_request = 0;

   function automatic int live_word_count();
      return (cfg_words > WORDS_MAX) ? WORDS_MAX : int'(cfg_words);
   endfunction

   // advance the frame tracker by one word and return the reply it owes
   function automatic rsp_word_type reply_of(req_word_type w);
      rsp_word_type r;
      int           words;
      int           etx;
      int           p;
      int           off;
      int           a;
      logic         good;
      r.done  = 1'b0;
      r.ok    = 1'b0;
      r.slave = 16'h0000;
      r.word  = 16'sh0000;
      if (w.action == frcc_pkg::ACT_TABLE_READ) begin
         if (w.read_slave >= 1 && w.read_slave <= SLAVES && w.read_index < DEPTH)
            r.word = tables[w.read_slave - 1][w.read_index];
         return r;
      end
      words = live_word_count();
      etx = frcc_pkg::HEADER_BYTES + 2 * words;
      if (w.frame_start)
         pos = 5'd0;
      p = int'(pos);
      // past the frame end: dropped, position held
      if (p > etx + 2)
         return r;
      if (p == 0) begin
         start_hit = (w.rx_byte == cfg_start_mark);
         sum = {8'h00, w.rx_byte};
      end else if (p <= etx) begin
         sum = sum + {8'h00, w.rx_byte};
         if (p == 1 || p == 2) begin
            hdr_slave = {hdr_slave[7:0], w.rx_byte};
         end else if (p == 4 || p == 5) begin
            hdr_start = {hdr_start[7:0], w.rx_byte};
         end else if (p == etx) begin
            end_hit = (w.rx_byte == cfg_end_mark);
         end else if (p >= frcc_pkg::HEADER_BYTES) begin
            off = p - frcc_pkg::HEADER_BYTES;
            if ((off % 2) == 0)
               hi_hold = w.rx_byte;
            else if ((off / 2) < WORDS_MAX)
               staged[off / 2] = {hi_hold, w.rx_byte};
         end
      end else if (p == etx + 1) begin
         hi_hold = w.rx_byte;
      end else begin
         // final checksum byte: report and commit
         good = start_hit && end_hit && ({hi_hold, w.rx_byte} == sum);
         r.done  = 1'b1;
         r.ok    = good;
         r.slave = hdr_slave;
         if (good && hdr_slave >= 1 && hdr_slave <= SLAVES) begin
            for (int k = 0; k < words; k++) begin
               a = int'(hdr_start) + k;
               if (a < DEPTH)
                  tables[hdr_slave - 1][a] = staged[k];
            end
         end
         pos = 5'd0;
         return r;
      end
      pos = 5'(p + 1);
      return r;
   endfunction

   function automatic req_word_type byte_word(logic [7:0] b, logic fs);
      req_word_type w;
      w.action      = frcc_pkg::ACT_FRAME_BYTE;
      w.rx_byte     = b;
      w.frame_start = fs;
      w.read_slave  = 2'($urandom_range(0, 3));
      w.read_index  = 4'($urandom_range(0, 15));
      return w;
   endfunction

   function automatic req_word_type table_read_req(logic [1:0] s, logic [3:0] i);
      req_word_type w;
      w.action      = frcc_pkg::ACT_TABLE_READ;
      w.rx_byte     = 8'($urandom_range(0, 255));
      w.frame_start = 1'($urandom_range(0, 1));
      w.read_slave  = s;
      w.read_index  = i;
      return w;
   endfunction

   // lay out one frame under the current markers into frame_bytes
   function automatic void build_frame(logic [15:0] slave, logic [7:0] func, logic [15:0] start,
                                       int nwords, damage_type dmg, bit use_fixed,
                                       logic [15:0] fixed_word);
      logic [15:0] s;
      logic [15:0] dw;
      logic [7:0]  flip;
      frame_bytes.delete();
      flip = 8'($urandom_range(1, 255));
      frame_bytes.push_back((dmg == DMG_START) ? (cfg_start_mark ^ flip) : cfg_start_mark);
      frame_bytes.push_back(slave[15:8]);
      frame_bytes.push_back(slave[7:0]);
      frame_bytes.push_back(func);
      frame_bytes.push_back(start[15:8]);
      frame_bytes.push_back(start[7:0]);
      for (int k = 0; k < nwords; k++) begin
         dw = use_fixed ? fixed_word : 16'($urandom);
         frame_bytes.push_back(dw[15:8]);
         frame_bytes.push_back(dw[7:0]);
      end
      frame_bytes.push_back((dmg == DMG_END) ? (cfg_end_mark ^ flip) : cfg_end_mark);
      s = 16'h0000;
      foreach (frame_bytes[i])
         s = s + {8'h00, frame_bytes[i]};
      if (dmg == DMG_SUM)
         s = s ^ {8'h00, flip};
      frame_bytes.push_back(s[15:8]);
      frame_bytes.push_back(s[7:0]);
   endfunction

   // offer one word on the request channel and wait until it is taken
   task automatic send_item(req_word_type w);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= w.action;
      req_ch.rx_byte     <= w.rx_byte;
      req_ch.frame_start <= w.frame_start;
      req_ch.read_slave  <= w.read_slave;
      req_ch.read_index  <= w.read_index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      owed_replies.push_back(reply_of(w));
      items_sent++;
   endtask

   // send frame_bytes[from..upto-1], with random table reads mixed in
   task automatic send_bytes(int from, int upto, logic fs_first, int read_pct);
      for (int i = from; i < upto; i++) begin
         if ($urandom_range(0, 99) < read_pct)
            send_item(table_read_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15))));
         send_item(byte_word(frame_bytes[i], (i == from) ? fs_first : 1'b0));
      end
   endtask

   // wait until every reply is in and any commit sweep has finished
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers while idle
   task automatic set_config(logic [7:0] sm, logic [7:0] em, logic [7:0] wc_data);
      logic [7:0]                     vals [3];
      logic [frcc_pkg::CSR_IDX_W-1:0] idx  [3];
      wait_idle();
      vals = '{sm, em, wc_data};
      idx  = '{frcc_pkg::CSR_START_MARKER, frcc_pkg::CSR_END_MARKER, frcc_pkg::CSR_WORD_COUNT};
      for (int i = 0; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         case (idx[i])
            frcc_pkg::CSR_START_MARKER: cfg_start_mark = vals[i];
            frcc_pkg::CSR_END_MARKER:   cfg_end_mark   = vals[i];
            frcc_pkg::CSR_WORD_COUNT:   cfg_words      = vals[i][3:0];
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random_frame(bit allow_damage);
      logic [15:0] slave;
      logic [15:0] start;
      damage_type  dmg;
      int          r;
      r = $urandom_range(0, 99);
      slave = (r < 80) ? 16'($urandom_range(1, SLAVES)) : ((r < 88) ? 16'h0000 : 16'($urandom));
      start = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, DEPTH + 2)) : 16'($urandom);
      dmg = DMG_NONE;
      if (allow_damage && $urandom_range(0, 99) < 20)
         dmg = damage_type'($urandom_range(1, 3));
      build_frame(slave, 8'($urandom), start, live_word_count(), dmg, 1'b0, 16'h0000);
      send_bytes(0, frame_bytes.size(), (pos != 0) || ($urandom_range(0, 3) == 0), 8);
   endtask

   // tables read back as zero after reset, frame_start ignored on a read
   task automatic test_reset_reads();
      req_word_type w;
      send_item(table_read_req(2'd1, 4'd0));
      send_item(table_read_req(2'd3, 4'd15));
      send_item(table_read_req(2'd0, 4'd7));
      w = table_read_req(2'd2, 4'd5);
      w.frame_start = 1'b1;
      send_item(w);
   endtask

   // frames under the reset register values
   task automatic test_reset_config_frames();
      repeat (4) send_random_frame(1'b0);
   endtask

   // marker extremes and a frame with no data words, no frame_start
   task automatic test_empty_frame();
      set_config(8'h00, 8'hFF, {4'hA, 4'd0});
      build_frame(16'd2, 8'h00, 16'd0, 0, DMG_NONE, 1'b0, 16'h0000);
      send_bytes(0, frame_bytes.size(), 1'b0, 0);
   endtask

   // start marker, end marker and checksum each spoiled
   task automatic test_bad_frames();
      for (int d = DMG_START; d <= DMG_SUM; d++) begin
         build_frame(16'd1, 8'h03, 16'd0, live_word_count(), damage_type'(d), 1'b0, 16'h0000);
         send_bytes(0, frame_bytes.size(), 1'b1, 0);
      end
   endtask

   // word count above the maximum, and a full frame running off the table end
   task automatic test_long_frame();
      set_config(8'h02, 8'h03, {4'h3, 4'd15});
      build_frame(16'd1, 8'h03, 16'd5, live_word_count(), DMG_NONE, 1'b0, 16'h0000);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      set_config(8'h02, 8'h03, {4'hC, 4'd11});
      build_frame(16'd2, 8'h03, 16'd8, live_word_count(), DMG_NONE, 1'b0, 16'h0000);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      send_item(table_read_req(2'd1, 4'd15));
      send_item(table_read_req(2'd2, 4'd15));
   endtask

   // last table entry, overrun, foreign slave, signed extremes and bad reads
   task automatic test_table_edges();
      set_config(8'hFF, 8'h00, {4'hF, 4'd1});
      build_frame(16'd3, 8'h10, 16'd15, 1, DMG_NONE, 1'b1, 16'h8000);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      build_frame(16'd1, 8'h10, 16'd16, 1, DMG_NONE, 1'b1, 16'h1111);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      build_frame(16'd1, 8'h10, 16'd0, 1, DMG_NONE, 1'b1, 16'h7FFF);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      build_frame(16'hFFFF, 8'hFF, 16'd1, 1, DMG_NONE, 1'b1, 16'h1234);
      send_bytes(0, frame_bytes.size(), 1'b1, 0);
      send_item(table_read_req(2'd3, 4'd15));
      send_item(table_read_req(2'd1, 4'd0));
      send_item(table_read_req(2'd0, 4'd3));
   endtask

   // word count lowered and raised in the middle of a frame
   task automatic test_word_count_change();
      set_config(8'h02, 8'h03, {4'h0, 4'd1});
      build_frame(16'd2, 8'h04, 16'd3, 1, DMG_NONE, 1'b0, 16'h0000);
      send_bytes(0, frame_bytes.size() - 1, 1'b1, 0);
      // shorter frame now: position is past the end, bytes get dropped
      set_config(8'h02, 8'h03, {4'h0, 4'd0});
      send_item(byte_word(8'($urandom), 1'b0));
      send_item(byte_word(8'($urandom), 1'b0));
      // header under zero words, data under one word
      build_frame(16'd3, 8'h04, 16'd2, 1, DMG_NONE, 1'b0, 16'h0000);
      send_bytes(0, frcc_pkg::HEADER_BYTES, 1'b1, 0);
      set_config(8'h02, 8'h03, {4'h0, 4'd1});
      send_bytes(frcc_pkg::HEADER_BYTES, frame_bytes.size(), 1'b0, 0);
      send_item(table_read_req(2'd3, 4'd2));
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_rsp_backpressure();
      set_config(8'($urandom), 8'($urandom), {4'($urandom_range(0, 15)), 4'd3});
      gaps_on = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (3) send_random_frame(1'b1);
      gaps_on = 1'b1;
   endtask

   // phases of random settings with mostly well formed frames
   task automatic test_random_phases();
      int          target;
      int          phase_end;
      int          r;
      logic [7:0]  sm;
      logic [7:0]  em;
      logic [3:0]  wc;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         sm = (r < 20) ? 8'h00 : ((r < 35) ? 8'hFF : 8'($urandom));
         r = $urandom_range(0, 99);
         em = (r < 20) ? 8'hFF : ((r < 35) ? 8'h00 : 8'($urandom));
         r = $urandom_range(0, 99);
         wc = (r < 40) ? 4'($urandom_range(0, 2)) :
              ((r < 70) ? 4'($urandom_range(3, 8)) : 4'($urandom_range(9, 15)));
         set_config(sm, em, {4'($urandom_range(0, 15)), wc});
         gaps_on = ($urandom_range(0, 3) != 0);
         phase_end = items_sent + $urandom_range(60, 160);
         while (items_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               send_random_frame(1'b1);
            end else if (r < 80) begin
               repeat ($urandom_range(1, 4))
                  send_item(table_read_req(2'($urandom_range(0, 3)),
                                           4'($urandom_range(0, 15))));
            end else if (r < 90) begin
               // noise bytes
               repeat ($urandom_range(1, 6))
                  send_item(byte_word(8'($urandom), 1'($urandom_range(0, 3) == 0)));
            end else begin
               // truncated frame, the next one restarts with frame_start
               build_frame(16'($urandom_range(1, SLAVES)), 8'($urandom),
                           16'($urandom_range(0, DEPTH)), live_word_count(),
                           DMG_NONE, 1'b0, 16'h0000);
               send_bytes(0, $urandom_range(1, frame_bytes.size() - 1), 1'b1, 8);
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // reply receiver: random stalls, checks every accepted word in order
   initial begin : reply_sink
      rsp_word_type want;
      int           stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = gaps_on ? $urandom_range(0, 10) : 0;
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (owed_replies.size() == 0) begin
            $display("%0t unexpected reply: done=%0b ok=%0b slave=%h word=%h", $time,
                     rsp_ch.frame_done, rsp_ch.frame_ok, rsp_ch.frame_slave, rsp_ch.read_word);
            errors++;
         end else begin
            want = owed_replies.pop_front();
            if (rsp_ch.frame_done !== want.done || rsp_ch.frame_ok !== want.ok ||
                rsp_ch.frame_slave !== want.slave || rsp_ch.read_word !== want.word) begin
               $display("%0t reply mismatch: expected done=%0b ok=%0b slave=%h word=%h",
                        $time, want.done, want.ok, want.slave, want.word);
               $display("%0t                 actual   done=%0b ok=%0b slave=%h word=%h",
                        $time, rsp_ch.frame_done, rsp_ch.frame_ok, rsp_ch.frame_slave,
                        rsp_ch.read_word);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.action      <= frcc_pkg::ACT_FRAME_BYTE;
      req_ch.rx_byte     <= 8'h00;
      req_ch.frame_start <= 1'b0;
      req_ch.read_slave  <= 2'd0;
      req_ch.read_index  <= 4'd0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= frcc_pkg::CSR_START_MARKER;
      csr_ch.data        <= 8'h00;

      // tracker state after reset
      cfg_start_mark = frcc_pkg::START_MARKER_RESET;
      cfg_end_mark   = frcc_pkg::END_MARKER_RESET;
      cfg_words      = frcc_pkg::WORD_COUNT_RESET;
      pos            = 5'd0;
      sum            = 16'h0000;
      hdr_slave      = 16'h0000;
      hdr_start      = 16'h0000;
      start_hit      = 1'b0;
      end_hit        = 1'b0;
      hi_hold        = 8'h00;
      foreach (staged[k])
         staged[k] = 16'h0000;
      foreach (tables[s, a])
         tables[s][a] = 16'h0000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_reads();
      test_reset_config_frames();
      test_empty_frame();
      test_bad_frames();
      test_long_frame();
      test_table_edges();
      test_word_count_change();
      test_rsp_backpressure();
      test_random_phases();

      wait_idle();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
